@@ design/ternary_dense_layer_macros.svh @@
// Assertion macros for the ternary dense layer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TERNARY_DENSE_LAYER_MACROS_SVH
`define TERNARY_DENSE_LAYER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define TDL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdl assertion failed");

// cons must hold in the cycle after ante
`define TDL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdl assertion failed");

`else

`define TDL_ASSERT_IMPLIES(label, ante, cons)
`define TDL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/tdl_pkg.sv @@
// Shared constants for the ternary dense layer.
// No dependencies; used by tdl_lane_sum and ternary_dense_layer.
`timescale 1ns / 1ps

package tdl_pkg;

    localparam int LANES       = 16;
    localparam int LANE_W      = 4;
    localparam int ACT_W       = 8;
    localparam int WORD_W      = 32;
    localparam int BIAS_W      = 32;
    localparam int LANE_SUM_W  = 13;   // 16 terms of +-128
    localparam int SUM_W       = 34;   // accumulator + lane sum + 32-bit bias
    localparam int INDEX_W     = 10;

    localparam int DEF_MAX_INPUTS  = 1024;
    localparam int DEF_MAX_OUTPUTS = 1024;

    localparam int OUT_MAX = 127;
    localparam int OUT_MIN = -128;

    // weight codes
    localparam logic [1:0] CODE_PLUS  = 2'b01;
    localparam logic [1:0] CODE_MINUS = 2'b11;

    // item kinds
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_WEIGHT = 1'b1;

    // configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] REG_RELU_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT = 2'd2;

    localparam logic                  RST_RELU_ENABLE  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_INPUT_COUNT  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_OUTPUT_COUNT = 11'd1024;

endpackage

@@ design/ternary_dense_layer.sv @@
// Ternary dense layer: func 0 words load activations into sixteen RAM banks, func 1 words
// carry sixteen 2-bit weights that are applied to the next sixteen activations of the row.
// One word is taken every cycle as long as results are taken; the rate is set by the
// single banked buffer read (all sixteen lanes in one row) and the adder tree behind it.
// A result reaches the output register once the row's final weight word, after it is
// accepted, has passed the input register, bank read and lane sum stages. The activation
// buffer needs no clearing after reset; load slots before weight words read them.
`timescale 1ns / 1ps
`include "ternary_dense_layer_macros.svh"

module ternary_dense_layer #(
    parameter int MAX_INPUTS  = tdl_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = tdl_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [tdl_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [tdl_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   func,
    input  logic signed [tdl_pkg::ACT_W-1:0]       act,
    input  logic [tdl_pkg::WORD_W-1:0]             weight_word,
    input  logic signed [tdl_pkg::BIAS_W-1:0]      bias,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tdl_pkg::ACT_W-1:0]       out_value,
    output logic [tdl_pkg::INDEX_W-1:0]            out_index,
    output logic                                   last_output
);

    localparam int LANES  = tdl_pkg::LANES;
    localparam int LANE_W = tdl_pkg::LANE_W;
    localparam int ACT_W  = tdl_pkg::ACT_W;
    localparam int CD_W   = tdl_pkg::CFG_DATA_W;
    localparam int SUM_W  = tdl_pkg::SUM_W;
    localparam int IX_W   = tdl_pkg::INDEX_W;
    localparam int ROWS   = (MAX_INPUTS + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LP_W   = $clog2(MAX_INPUTS);
    localparam int NC_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int NIN_W  = $clog2(MAX_INPUTS + 1);
    localparam int NOUT_W = $clog2(MAX_OUTPUTS + 1);
    localparam int CI_W   = (CD_W > NIN_W) ? CD_W : NIN_W;
    localparam int CO_W   = (CD_W > NOUT_W) ? CD_W : NOUT_W;
    localparam int MW     = CI_W + ROW_W + LANE_W;
    localparam int ACC_W  = $clog2(MAX_INPUTS) + ACT_W + 1;

    // configuration
    logic            relu_enable_reg;
    logic [CD_W-1:0] input_count_reg;
    logic [CD_W-1:0] output_count_reg;

    // sequencing counters
    logic [LP_W-1:0]  load_pointer_reg,   load_pointer_next;
    logic [ROW_W-1:0] word_in_row_reg,    word_in_row_next;
    logic [NC_W-1:0]  neuron_counter_reg, neuron_counter_next;

    // stage 1: input register
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_weight_reg;
    logic [ACT_W-1:0]         s1_act_reg;
    logic [LP_W-1:0]          s1_lp_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [tdl_pkg::WORD_W-1:0] s1_word_reg;
    logic [LANES-1:0]         s1_mask_reg;
    logic signed [tdl_pkg::BIAS_W-1:0] s1_bias_reg;
    logic                     s1_final_reg;
    logic [IX_W-1:0]          s1_index_reg;
    logic                     s1_last_reg;

    // stage 2: bank read data
    logic                     s2_valid_reg, s2_valid_next;
    logic [tdl_pkg::WORD_W-1:0] s2_word_reg;
    logic [LANES-1:0]         s2_mask_reg;
    logic signed [tdl_pkg::BIAS_W-1:0] s2_bias_reg;
    logic                     s2_final_reg;
    logic [IX_W-1:0]          s2_index_reg;
    logic                     s2_last_reg;
    logic [LANES-1:0][ACT_W-1:0] bank_data;

    // stage 3: lane sum
    logic                     s3_valid_reg, s3_valid_next;
    logic signed [tdl_pkg::LANE_SUM_W-1:0] s3_sum_reg;
    logic signed [tdl_pkg::BIAS_W-1:0] s3_bias_reg;
    logic                     s3_final_reg;
    logic [IX_W-1:0]          s3_index_reg;
    logic                     s3_last_reg;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic signed [ACT_W-1:0]  out_value_reg;
    logic [IX_W-1:0]          out_index_reg;
    logic                     out_last_reg;

    logic signed [tdl_pkg::LANE_SUM_W-1:0] lane_sum;

    // flow control, from the output back
    logic out_free, s3_go, s3_free, s2_free, s1_go, s1_free, in_fire, rd_en;

    assign out_free = !out_valid_reg || out_ready;
    assign s3_go    = !s3_final_reg || out_free;
    assign s3_free  = !s3_valid_reg || s3_go;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_go    = !s1_weight_reg || s2_free;   // loads retire into the banks at once
    assign s1_free  = !s1_valid_reg || s1_go;
    assign in_ready = s1_free;
    assign in_fire  = in_valid && in_ready;
    assign rd_en    = s1_valid_reg && s1_weight_reg && s2_free;

    // ---------------------------------------------------------------------
    // Decode at accept time, from the current counters
    // ---------------------------------------------------------------------
    logic [CI_W-1:0]  in_cfg, n_in;
    logic [CO_W-1:0]  out_cfg, n_out;
    logic [CI_W:0]    words;
    logic             row_last, layer_last, fire_is_weight;
    logic [LANES-1:0] lane_mask;

    always_comb
    begin
        logic [MW-1:0] base;
        in_cfg  = CI_W'(input_count_reg);
        out_cfg = CO_W'(output_count_reg);
        if (in_cfg == '0)
            n_in = CI_W'(1);
        else if (in_cfg > CI_W'(MAX_INPUTS))
            n_in = CI_W'(MAX_INPUTS);
        else
            n_in = in_cfg;
        if (out_cfg == '0)
            n_out = CO_W'(1);
        else if (out_cfg > CO_W'(MAX_OUTPUTS))
            n_out = CO_W'(MAX_OUTPUTS);
        else
            n_out = out_cfg;

        words      = ((CI_W+1)'(n_in) + (CI_W+1)'(LANES - 1)) >> LANE_W;
        row_last   = (MW'(word_in_row_reg) + MW'(1)) >= MW'(words);
        layer_last = ((CO_W+1)'(neuron_counter_reg) + (CO_W+1)'(1)) >= (CO_W+1)'(n_out);

        base = MW'(word_in_row_reg) << LANE_W;
        for (int l = 0; l < LANES; l++)
        begin
            lane_mask[l] = (base + MW'(l)) < MW'(n_in);
        end
        fire_is_weight = (func == tdl_pkg::FUNC_WEIGHT);
    end

    always_comb
    begin
        load_pointer_next   = load_pointer_reg;
        word_in_row_next    = word_in_row_reg;
        neuron_counter_next = neuron_counter_reg;
        if (in_fire)
        begin
            if (!fire_is_weight)
            begin
                if (load_pointer_reg == LP_W'(MAX_INPUTS - 1))
                    load_pointer_next = '0;
                else
                    load_pointer_next = load_pointer_reg + LP_W'(1);
            end
            else if (!row_last)
            begin
                word_in_row_next = word_in_row_reg + ROW_W'(1);
            end
            else
            begin
                word_in_row_next = '0;
                if (layer_last)
                begin
                    neuron_counter_next = '0;
                    load_pointer_next   = '0;   // next layer pass reloads from slot 0
                end
                else
                begin
                    neuron_counter_next = neuron_counter_reg + NC_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage valids, accumulator, result
    // ---------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_full;
    logic signed [ACT_W-1:0] sat_value;

    always_comb
    begin
        s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_free ? (s1_valid_reg && s1_weight_reg) : s2_valid_reg;
        s3_valid_next = s3_free ? s2_valid_reg : s3_valid_reg;

        acc_next = acc_reg;
        if (s3_valid_reg && s3_go)
        begin
            if (s3_final_reg)
                acc_next = '0;
            else
                acc_next = acc_reg + ACC_W'(s3_sum_reg);
        end

        sum_full = SUM_W'(acc_reg) + SUM_W'(s3_sum_reg) + SUM_W'(s3_bias_reg);
        if (relu_enable_reg && sum_full < 0)
            sat_value = '0;
        else if (sum_full > SUM_W'(tdl_pkg::OUT_MAX))
            sat_value = ACT_W'(tdl_pkg::OUT_MAX);
        else if (sum_full < SUM_W'(tdl_pkg::OUT_MIN))
            sat_value = ACT_W'(tdl_pkg::OUT_MIN);
        else
            sat_value = sum_full[ACT_W-1:0];

        if (s3_valid_reg && s3_final_reg && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_enable_reg    <= tdl_pkg::RST_RELU_ENABLE;
            input_count_reg    <= tdl_pkg::RST_INPUT_COUNT;
            output_count_reg   <= tdl_pkg::RST_OUTPUT_COUNT;
            load_pointer_reg   <= '0;
            word_in_row_reg    <= '0;
            neuron_counter_reg <= '0;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            s3_valid_reg       <= 1'b0;
            acc_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    tdl_pkg::REG_RELU_ENABLE:  relu_enable_reg  <= cfg_data[0];
                    tdl_pkg::REG_INPUT_COUNT:  input_count_reg  <= cfg_data;
                    tdl_pkg::REG_OUTPUT_COUNT: output_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            load_pointer_reg   <= load_pointer_next;
            word_in_row_reg    <= word_in_row_next;
            neuron_counter_reg <= neuron_counter_next;
            s1_valid_reg       <= s1_valid_next;
            s2_valid_reg       <= s2_valid_next;
            s3_valid_reg       <= s3_valid_next;
            acc_reg            <= acc_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_weight_reg <= fire_is_weight;
            s1_act_reg    <= act;
            s1_lp_reg     <= load_pointer_reg;
            s1_row_reg    <= word_in_row_reg;
            s1_word_reg   <= weight_word;
            s1_mask_reg   <= lane_mask;
            s1_bias_reg   <= bias;
            s1_final_reg  <= row_last;
            s1_index_reg  <= IX_W'(neuron_counter_reg);
            s1_last_reg   <= layer_last;
        end
        if (rd_en)
        begin
            s2_word_reg  <= s1_word_reg;
            s2_mask_reg  <= s1_mask_reg;
            s2_bias_reg  <= s1_bias_reg;
            s2_final_reg <= s1_final_reg;
            s2_index_reg <= s1_index_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_sum_reg   <= lane_sum;
            s3_bias_reg  <= s2_bias_reg;
            s3_final_reg <= s2_final_reg;
            s3_index_reg <= s2_index_reg;
            s3_last_reg  <= s2_last_reg;
        end
        if (s3_valid_reg && s3_final_reg && out_free)
        begin
            out_value_reg <= sat_value;
            out_index_reg <= s3_index_reg;
            out_last_reg  <= s3_last_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Activation banks: slot i lives in bank i%16, row i/16
    // ---------------------------------------------------------------------
    for (genvar l = 0; l < LANES; l++)
    begin : g_bank
        tdl_ram #(
            .WIDTH (ACT_W),
            .DEPTH (ROWS)
        ) u_bank (
            .clk     (clk),
            .wr_en   (s1_valid_reg && !s1_weight_reg &&
                      (s1_lp_reg[LANE_W-1:0] == LANE_W'(l))),
            .wr_addr (ROW_W'(s1_lp_reg >> LANE_W)),
            .wr_data (s1_act_reg),
            .rd_en   (rd_en),
            .rd_addr (s1_row_reg),
            .rd_data (bank_data[l])
        );
    end

    tdl_lane_sum u_lane_sum (
        .acts (bank_data),
        .word (s2_word_reg),
        .mask (s2_mask_reg),
        .sum  (lane_sum)
    );

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_index   = out_index_reg;
    assign last_output = out_last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `TDL_ASSERT_NEXT(a_layer_rewind, in_fire && fire_is_weight && row_last && layer_last, neuron_counter_reg == '0 && load_pointer_reg == '0 && word_in_row_reg == '0)
    `TDL_ASSERT_IMPLIES(a_s3_stall, s3_valid_reg && !s3_go, s3_final_reg && out_valid_reg && !out_ready)
    `TDL_ASSERT_NEXT(a_out_source, !out_valid_reg && !(s3_valid_reg && s3_final_reg), !out_valid_reg)
    `TDL_ASSERT_NEXT(a_acc_clear, s3_valid_reg && s3_final_reg && s3_go, acc_reg == '0)

endmodule

@@ design/tdl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/tdl_lane_sum.sv @@
// Sixteen-lane ternary multiply and adder tree for one weight word.
// Depends on tdl_pkg.
`timescale 1ns / 1ps

module tdl_lane_sum (
    input  logic [tdl_pkg::LANES-1:0][tdl_pkg::ACT_W-1:0] acts,
    input  logic [tdl_pkg::WORD_W-1:0]                    word,
    input  logic [tdl_pkg::LANES-1:0]                     mask,
    output logic signed [tdl_pkg::LANE_SUM_W-1:0]         sum
);

    localparam int TW = tdl_pkg::ACT_W + 1;

    logic signed [TW-1:0]   term [tdl_pkg::LANES];
    logic signed [TW:0]     lvl1 [8];
    logic signed [TW+1:0]   lvl2 [4];
    logic signed [TW+2:0]   lvl3 [2];

    always_comb
    begin
        logic [1:0]                       code;
        logic signed [tdl_pkg::ACT_W-1:0] a;
        for (int l = 0; l < tdl_pkg::LANES; l++)
        begin
            code = word[2*l +: 2];
            a    = $signed(acts[l]);
            if (!mask[l])
                term[l] = '0;
            else if (code == tdl_pkg::CODE_PLUS)
                term[l] = TW'(a);
            else if (code == tdl_pkg::CODE_MINUS)
                term[l] = -TW'(a);
            else
                term[l] = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lvl1[i] = (TW+1)'(term[2*i]) + (TW+1)'(term[2*i+1]);
        end
        for (int i = 0; i < 4; i++)
        begin
            lvl2[i] = (TW+2)'(lvl1[2*i]) + (TW+2)'(lvl1[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            lvl3[i] = (TW+3)'(lvl2[2*i]) + (TW+3)'(lvl2[2*i+1]);
        end
        sum = tdl_pkg::LANE_SUM_W'(lvl3[0]) + tdl_pkg::LANE_SUM_W'(lvl3[1]);
    end

endmodule

@@ tb/tb_ternary_dense_layer.sv @@
// Self-checking testbench for ternary_dense_layer: streams activation loads and packed
// ternary weight words, predicts every neuron output in place and compares each one.
// Depends on tdl_pkg and the ternary_dense_layer RTL.
`timescale 1ns / 1ps

module tb_ternary_dense_layer;

    localparam int ACT_W         = tdl_pkg::ACT_W;
    localparam int WORD_W        = tdl_pkg::WORD_W;
    localparam int BIAS_W        = tdl_pkg::BIAS_W;
    localparam int INDEX_W       = tdl_pkg::INDEX_W;
    localparam int LANES         = tdl_pkg::LANES;
    localparam int CFG_INDEX_W   = tdl_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W    = tdl_pkg::CFG_DATA_W;
    localparam int CLK_HALF      = 4;
    localparam int MAX_IN        = tdl_pkg::DEF_MAX_INPUTS;
    localparam int MAX_OUT       = tdl_pkg::DEF_MAX_OUTPUTS;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int FRESH_LOADS   = 48;
    localparam int PHASE_WORDS   = 35;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;   // decodes to no register
    localparam logic [1:0] CODE_ZERO_HIGH = 2'b10;          // the second zero weight code

    typedef struct packed {
        logic signed [ACT_W-1:0] value;
        logic [INDEX_W-1:0]      index;
        logic                    last;
    } neuron_out_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      func = tdl_pkg::FUNC_LOAD;
    logic signed [ACT_W-1:0]   act = '0;
    logic [WORD_W-1:0]         weight_word = '0;
    logic signed [BIAS_W-1:0]  bias = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [ACT_W-1:0]   out_value;
    logic [INDEX_W-1:0]        out_index;
    logic                      last_output;

    // predictor state
    logic signed [ACT_W-1:0]   act_mem [MAX_IN];
    int                        hi_water = 0;      // slots below this have been loaded
    int                        load_ptr = 0;
    int                        row_word = 0;
    int                        neuron_idx = 0;
    longint                    row_sum = 0;
    logic                      relu_on = tdl_pkg::RST_RELU_ENABLE;
    logic [CFG_DATA_W-1:0]     in_count_reg = tdl_pkg::RST_INPUT_COUNT;
    logic [CFG_DATA_W-1:0]     out_count_reg = tdl_pkg::RST_OUTPUT_COUNT;
    bit                        layer_done = 1'b0;
    neuron_out_t               pending_neurons [$];

    int                        mismatch_count = 0;
    int                        send_idle_pct = 0;
    int                        recv_stall_pct = 0;
    int                        idle_cycles = 0;

    ternary_dense_layer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .act         (act),
        .weight_word (weight_word),
        .bias        (bias),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .out_index   (out_index),
        .last_output (last_output)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic int clamp_count(input logic [CFG_DATA_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    // true when every live slot of the next weight word has been loaded
    function automatic bit row_loaded();
        int n_in;
        int top;
        n_in = clamp_count(in_count_reg, MAX_IN);
        top = row_word * LANES + LANES;
        if (top > n_in)
            top = n_in;
        return top <= hi_water;
    endfunction

    task automatic accumulate_word(input logic f, input logic signed [ACT_W-1:0] a,
                                   input logic [WORD_W-1:0] w,
                                   input logic signed [BIAS_W-1:0] b);
        int          n_in;
        int          n_out;
        int          words;
        int          lane;
        int          idx;
        logic [1:0]  code;
        longint      total;
        neuron_out_t res;
        if (f == tdl_pkg::FUNC_LOAD)
        begin
            act_mem[load_ptr] = a;
            if (load_ptr >= hi_water)
                hi_water = load_ptr + 1;
            load_ptr = (load_ptr + 1) % MAX_IN;
            return;
        end
        n_in = clamp_count(in_count_reg, MAX_IN);
        n_out = clamp_count(out_count_reg, MAX_OUT);
        words = (n_in + LANES - 1) / LANES;
        for (lane = 0; lane < LANES; lane++)
        begin
            idx = row_word * LANES + lane;
            code = w[2*lane +: 2];
            if (idx < n_in)
            begin
                if (code == tdl_pkg::CODE_PLUS)
                    row_sum += act_mem[idx];
                else if (code == tdl_pkg::CODE_MINUS)
                    row_sum -= act_mem[idx];
            end
        end
        if (row_word + 1 < words)
        begin
            row_word++;
            return;
        end
        total = row_sum + longint'(b);
        if (relu_on && total < 0)
            total = 0;
        if (total > tdl_pkg::OUT_MAX)
            total = tdl_pkg::OUT_MAX;
        if (total < tdl_pkg::OUT_MIN)
            total = tdl_pkg::OUT_MIN;
        res.value = total[ACT_W-1:0];
        res.index = neuron_idx[INDEX_W-1:0];
        res.last = (neuron_idx + 1 >= n_out);
        pending_neurons.push_back(res);
        row_sum = 0;
        row_word = 0;
        if (res.last)
        begin
            neuron_idx = 0;
            load_ptr = 0;
            layer_done = 1'b1;
        end
        else
            neuron_idx++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_outputs
        neuron_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_neurons.size() == 0)
                report_mismatch($sformatf("unexpected output, index %0d", out_index));
            else
            begin
                want = pending_neurons.pop_front();
                if (out_value !== want.value)
                    report_mismatch($sformatf("neuron %0d value: got %0d, want %0d",
                                              want.index, out_value, want.value));
                if (out_index !== want.index)
                    report_mismatch($sformatf("index: got %0d, want %0d",
                                              out_index, want.index));
                if (last_output !== want.last)
                    report_mismatch($sformatf("neuron %0d last flag: got %b, want %b",
                                              want.index, last_output, want.last));
            end
        end
    end

    // ends the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays high for a following word
    task automatic send_word(input logic f, input logic signed [ACT_W-1:0] a,
                             input logic [WORD_W-1:0] w,
                             input logic signed [BIAS_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        act <= a;
        weight_word <= w;
        bias <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_word(f, a, w, b);
        @(negedge clk);
    endtask

    task automatic send_load(input logic signed [ACT_W-1:0] a);
        send_word(tdl_pkg::FUNC_LOAD, a, $urandom, $urandom);
    endtask

    task automatic send_weights(input logic [WORD_W-1:0] w, input logic signed [BIAS_W-1:0] b);
        send_word(tdl_pkg::FUNC_WEIGHT, ACT_W'($urandom), w, b);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_neurons.size() != 0);
    endtask

    task automatic set_layer(input logic relu, input logic [CFG_DATA_W-1:0] n_in,
                             input logic [CFG_DATA_W-1:0] n_out);
        logic [CFG_DATA_W-2:0] junk;
        drain_outputs();
        // a non-final word may still be in the pipe
        repeat (SETTLE_CYCLES) @(negedge clk);
        junk = (CFG_DATA_W-1)'($urandom);
        cfg_write <= 1'b1;
        cfg_index <= tdl_pkg::REG_RELU_ENABLE;
        cfg_data <= {junk, relu};   // only bit 0 counts
        relu_on = relu;
        @(negedge clk);
        cfg_index <= tdl_pkg::REG_INPUT_COUNT;
        cfg_data <= n_in;
        in_count_reg = n_in;
        @(negedge clk);
        cfg_index <= tdl_pkg::REG_OUTPUT_COUNT;
        cfg_data <= n_out;
        out_count_reg = n_out;
        @(negedge clk);
        cfg_index <= REG_SPARE;
        cfg_data <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // two neurons of 17 inputs: extreme activations, every code, masked lanes, bias extremes
    task automatic test_mixed_codes();
        int                    i;
        logic [WORD_W-1:0]     w;
        logic signed [ACT_W-1:0] a;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_layer(1'b0, 11'd17, 11'd2);
        for (i = 0; i < 17; i++)
        begin
            case (i)
                0: a = -8'sd128;
                1: a = 8'sd127;
                2: a = -8'sd1;
                3: a = 8'sd1;
                4: a = 8'sd0;
                default: a = ACT_W'($urandom);
            endcase
            send_load(a);
        end
        send_weights(32'h5555_5555, $urandom);        // bias ignored mid-row
        w = $urandom;
        w[1:0] = tdl_pkg::CODE_MINUS;
        send_weights(w, 32'sh7FFF_FFFF);
        send_weights(32'hE4E4_E4E4, $urandom);        // codes 0,1,2,3 lane by lane
        send_weights(32'hFFFF_FFFD, 32'sh8000_0000);  // lanes above 0 are masked
    endtask

    // zero counts act as one: every weight word closes a one-neuron layer
    task automatic test_single_input_layers();
        int                       r;
        int                       i;
        logic [WORD_W-1:0]        w;
        logic signed [BIAS_W-1:0] b;
        send_idle_pct = 19;
        recv_stall_pct = 19;
        for (r = 1; r >= 0; r--)
        begin
            set_layer(r[0], 11'd0, 11'd0);
            for (i = 0; i < 8; i++)
            begin
                case (i)
                    0: b = -32'sd129;
                    1: b = -32'sd1;
                    2: b = -32'sd128;
                    3: b = 32'sd0;
                    4: b = 32'sd127;
                    5: b = 32'sd1;
                    6: b = 32'sd128;
                    default: b = 32'sh7FFF_FFFF;
                endcase
                w = $urandom;
                if (i % 2 == 0)
                    w[1:0] = CODE_ZERO_HIGH;   // sum is the bias alone
                send_load(ACT_W'($urandom));
                send_weights(w, b);
            end
        end
    endtask

    // loads past the input count land in slots that the masked lanes never use
    task automatic test_extra_loads();
        int i;
        send_idle_pct = 86;
        recv_stall_pct = 0;
        set_layer(1'b0, 11'd40, 11'd2);
        for (i = 0; i < 45; i++)
            send_load(ACT_W'($urandom));
        for (i = 0; i < 6; i++)
            send_weights($urandom & $urandom, int'($urandom_range(0, 200)) - 100);
    endtask

    // output count above the maximum keeps the layer open; lowering it below the
    // neuron counter mid-layer closes the layer on the next neuron
    task automatic test_long_layer();
        int i;
        send_idle_pct = 0;
        recv_stall_pct = 86;
        set_layer(1'b1, 11'd1, 11'd2047);
        send_load(ACT_W'($urandom));
        for (i = 0; i < 30; i++)
            send_weights($urandom, int'($urandom_range(0, 300)) - 150);
        set_layer(1'b1, 11'd1, 11'd20);
        send_weights($urandom, int'($urandom_range(0, 300)) - 150);
    endtask

    task automatic test_random_traffic();
        int                       phase;
        int                       k;
        int                       n_in;
        int                       pending_loads;
        logic [CFG_DATA_W-1:0]    in_sel;
        logic [CFG_DATA_W-1:0]    out_sel;
        logic [WORD_W-1:0]        w;
        logic signed [BIAS_W-1:0] b;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 19;
                    recv_stall_pct = 19;
                end
            endcase
            case ($urandom_range(0, 9))
                0: in_sel = 11'd0;
                1: in_sel = 11'd1024;
                2: in_sel = 11'd2047;
                3: in_sel = 11'd16;
                default: in_sel = CFG_DATA_W'($urandom_range(1, 48));
            endcase
            case ($urandom_range(0, 9))
                0: out_sel = 11'd0;
                1: out_sel = 11'd1024;
                2: out_sel = 11'd2047;
                default: out_sel = CFG_DATA_W'($urandom_range(1, 6));
            endcase
            // counters may sit mid-row or mid-layer here; new counts apply at once
            set_layer(1'($urandom_range(0, 1)), in_sel, out_sel);
            layer_done = (neuron_idx == 0 && row_word == 0);
            pending_loads = 0;
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                if (layer_done)
                begin
                    layer_done = 1'b0;
                    n_in = clamp_count(in_count_reg, MAX_IN);
                    if ($urandom_range(0, 3) != 0)
                        pending_loads = (n_in < FRESH_LOADS) ? n_in : FRESH_LOADS;
                end
                if (k == PHASE_WORDS / 2 || $urandom_range(0, 39) == 0)
                    drain_outputs();
                if (pending_loads > 0)
                begin
                    send_load(ACT_W'($urandom));
                    pending_loads--;
                end
                else if ($urandom_range(0, 11) == 0 || !row_loaded())
                    send_load(ACT_W'($urandom));   // stray load shifts the pointer
                else
                begin
                    case ($urandom_range(0, 2))
                        0: w = $urandom & $urandom;
                        1: w = $urandom | $urandom;
                        default: w = $urandom;
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        b = $urandom;
                    else
                        b = int'($urandom_range(0, 400)) - 200;
                    send_weights(w, b);
                end
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_mixed_codes();
        test_single_input_layers();
        test_extra_loads();
        test_long_layer();
        test_random_traffic();
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
